### design/assert_macros.svh
// Assertion helpers included by the read command sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

### design/lrcs_pkg.sv
package lrcs_pkg;

   localparam int DISK_COUNT      = 16;
   localparam int BLOCKS_PER_DISK = 256;
   localparam int BLOCK_BYTES     = 256;
   localparam int MAX_READ_BYTES  = 1024;
   localparam int MAX_RESULTS     = 8;

   localparam int DISK_BYTES   = BLOCKS_PER_DISK * BLOCK_BYTES;
   localparam int ARRAY_BYTES  = DISK_BYTES * DISK_COUNT;
   localparam int DISK_SHIFT   = $clog2(DISK_BYTES);
   localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);

   localparam int START_W  = 20;
   localparam int LEN_W    = 11;
   localparam int ADDR_W   = START_W + 1;
   localparam int CHUNK_W  = $clog2(BLOCK_BYTES) + 1;
   localparam int TOTAL_W  = 10;
   localparam int DISK_W   = 4;
   localparam int BLOCK_W  = 8;
   localparam int OFS_W    = 8;
   localparam int LENO_W   = 9;
   localparam int CODE_W   = 6;
   localparam int COUNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] KIND_SEEK_DISK  = 2'd0;
   localparam logic [1:0] KIND_SEEK_BLOCK = 2'd1;
   localparam logic [1:0] KIND_READ_BLOCK = 2'd2;
   localparam logic [1:0] KIND_ERROR      = 2'd3;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NOT_MOUNTED = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG    = 2'd2;
   localparam logic [1:0] STATUS_PAST_END    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MOUNTED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEEK_DISK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEEK_BLOCK = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_BLOCK = 2'd3;

   typedef struct packed {
      logic [DISK_W-1:0]  disk;
      logic [BLOCK_W-1:0] block;
      logic [OFS_W-1:0]   ofs;
      logic [CHUNK_W-1:0] chunk;
      logic [ADDR_W-1:0]  sum;
      logic [LEN_W-1:0]   next_left;
      logic               next_block_zero;
   } step_type;

endpackage

### design/linear_read_command_sequencer.sv
// Read request splitter for a linear array of disks laid end to end.
// A request (start address, length) enters on the req_ channel; the block is
// ready only while idle. Each request is checked against the mount bit, the
// maximum length and the array end. A failed check gives one error item.
// Otherwise the block sends a seek-to-disk, a seek-to-block and one read
// command per block touched, with a seek-to-disk wherever the read runs into
// the next disk. The final item of a request carries last and the byte total.
// An accepted request enters the check state, which registers its first item
// into the output register for rsp_. While the receiver keeps rsp_ready high,
// the sequencer produces one item per cycle through the shared address adder,
// up to eight items per request, and takes no new request until the last.
// When rsp_ready is low the output register holds its item and the sequencer
// waits; nothing is dropped. Control registers are written on the csr_ port,
// which is always ready. Reset clears the sequencer and the output valid flag and
// restores the command codes to their defaults with the array unmounted.
module linear_read_command_sequencer
   import lrcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [START_W-1:0]   req_start_address,
   input  logic [LEN_W-1:0]     req_length,
   input  logic                 req_end_check_high,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_command_word,
   output logic [1:0]           rsp_kind,
   output logic [DISK_W-1:0]    rsp_disk_number,
   output logic [BLOCK_W-1:0]   rsp_block_number,
   output logic [OFS_W-1:0]     rsp_byte_offset,
   output logic [LENO_W-1:0]    rsp_chunk_length,
   output logic [1:0]           rsp_status,
   output logic [TOTAL_W-1:0]   rsp_total_bytes,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]    csr_data
);

`include "assert_macros.svh"

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_CHECK      = 3'd1;
   localparam logic [2:0] S_SEEK_BLOCK = 3'd2;
   localparam logic [2:0] S_READ       = 3'd3;
   localparam logic [2:0] S_SEEK_DISK  = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_RESULTS);

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [LEN_W-1:0]    left_ff, left_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                mounted_ff;
   logic [CODE_W-1:0]   code_sd_ff, code_sb_ff, code_rb_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         word_ff, word_in;
   logic [1:0]          kind_ff, kind_in;
   logic [DISK_W-1:0]   disk_ff, disk_in;
   logic [BLOCK_W-1:0]  block_ff, block_in;
   logic [OFS_W-1:0]    ofs_ff, ofs_in;
   logic [LENO_W-1:0]   chunk_ff, chunk_in;
   logic [1:0]          status_ff, status_in;
   logic [TOTAL_W-1:0]  rtotal_ff, rtotal_in;
   logic                last_ff, last_in;

   step_type            step;
   logic                slot;
   logic                emit;
   logic                count_full;
   logic [TOTAL_W-1:0]  total_after;
   logic                more;

   lrcs_step_unit u_step (
      .addr       (addr_ff),
      .left       (left_ff),
      .check_mode (state_ff == S_CHECK),
      .step       (step)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign slot      = !rsp_valid_ff || rsp_ready;
   assign count_full  = (count_ff + COUNT_W'(1)) >= COUNT_MAX;
   assign total_after = total_ff + TOTAL_W'(step.chunk);
   assign more        = (step.next_left != '0) && !count_full;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      emit         = 1'b0;
      word_in      = word_ff;
      kind_in      = kind_ff;
      disk_in      = disk_ff;
      block_in     = block_ff;
      ofs_in       = '0;
      chunk_in     = '0;
      status_in    = STATUS_OK;
      rtotal_in    = '0;
      last_in      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               addr_in  = ADDR_W'(req_start_address);
               left_in  = req_length;
               total_in = '0;
               count_in = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (slot) begin
               emit = 1'b1;
               if (!mounted_ff || (32'(left_ff) >= 32'(MAX_READ_BYTES)) ||
                   (32'(addr_ff) >= 32'(ARRAY_BYTES)) ||
                   (32'(step.sum) > 32'(ARRAY_BYTES))) begin
                  word_in  = '0;
                  kind_in  = KIND_ERROR;
                  disk_in  = '0;
                  block_in = '0;
                  last_in  = 1'b1;
                  if (!mounted_ff) begin
                     status_in = STATUS_NOT_MOUNTED;
                  end else if (32'(left_ff) >= 32'(MAX_READ_BYTES)) begin
                     status_in = STATUS_TOO_LONG;
                  end else begin
                     status_in = STATUS_PAST_END;
                  end
                  state_in = S_IDLE;
               end else begin
                  word_in  = {14'b0, {BLOCK_W{1'b0}}, step.disk, code_sd_ff};
                  kind_in  = KIND_SEEK_DISK;
                  disk_in  = step.disk;
                  block_in = step.block;
                  count_in = count_ff + COUNT_W'(1);
                  state_in = S_SEEK_BLOCK;
               end
            end
         end
         S_SEEK_BLOCK: begin
            if (slot) begin
               emit     = 1'b1;
               word_in  = {14'b0, step.block, {DISK_W{1'b0}}, code_sb_ff};
               kind_in  = KIND_SEEK_BLOCK;
               disk_in  = step.disk;
               block_in = step.block;
               count_in = count_ff + COUNT_W'(1);
               last_in  = (left_ff == '0) || count_full;
               rtotal_in = last_in ? total_ff : '0;
               state_in = last_in ? S_IDLE : S_READ;
            end
         end
         S_READ: begin
            if (slot) begin
               emit     = 1'b1;
               word_in  = {14'b0, {BLOCK_W{1'b0}}, {DISK_W{1'b0}}, code_rb_ff};
               kind_in  = KIND_READ_BLOCK;
               disk_in  = step.disk;
               block_in = step.block;
               ofs_in   = step.ofs;
               chunk_in = LENO_W'(step.chunk);
               addr_in  = step.sum;
               left_in  = step.next_left;
               total_in = total_after;
               count_in = count_ff + COUNT_W'(1);
               last_in  = !more;
               rtotal_in = more ? '0 : total_after;
               if (!more) begin
                  state_in = S_IDLE;
               end else if (step.next_block_zero) begin
                  state_in = S_SEEK_DISK;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_SEEK_DISK: begin
            if (slot) begin
               emit     = 1'b1;
               word_in  = {14'b0, {BLOCK_W{1'b0}}, step.disk, code_sd_ff};
               kind_in  = KIND_SEEK_DISK;
               disk_in  = step.disk;
               block_in = step.block;
               count_in = count_ff + COUNT_W'(1);
               last_in  = count_full;
               rtotal_in = count_full ? total_ff : '0;
               state_in = count_full ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         addr_ff      <= '0;
         left_ff      <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         left_ff      <= left_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         word_ff   <= word_in;
         kind_ff   <= kind_in;
         disk_ff   <= disk_in;
         block_ff  <= block_in;
         ofs_ff    <= ofs_in;
         chunk_ff  <= chunk_in;
         status_ff <= status_in;
         rtotal_ff <= rtotal_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mounted_ff <= 1'b0;
         code_sd_ff <= CODE_W'(2);
         code_sb_ff <= CODE_W'(3);
         code_rb_ff <= CODE_W'(4);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOUNTED:    mounted_ff <= csr_data[0];
            CSR_SEEK_DISK:  code_sd_ff <= csr_data;
            CSR_SEEK_BLOCK: code_sb_ff <= csr_data;
            CSR_READ_BLOCK: code_rb_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_word = word_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_disk_number  = disk_ff;
   assign rsp_block_number = block_ff;
   assign rsp_byte_offset  = ofs_ff;
   assign rsp_chunk_length = chunk_ff;
   assign rsp_status       = status_ff;
   assign rsp_total_bytes  = rtotal_ff;
   assign rsp_last         = last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_MAX)
   `ASSERT_IMPLY(a_error_last, clock, reset, rsp_valid_ff && (kind_ff == KIND_ERROR),
                 last_ff && (status_ff != STATUS_OK))
   `ASSERT_IMPLY(a_disk_seek_left, clock, reset, state_ff == S_SEEK_DISK,
                 (left_ff != '0) && (count_ff < COUNT_MAX))

endmodule

### design/lrcs_step_unit.sv
module lrcs_step_unit
   import lrcs_pkg::*;
(
   input  logic [ADDR_W-1:0] addr,
   input  logic [LEN_W-1:0]  left,
   input  logic              check_mode,
   output step_type          step
);

   localparam int CMP_W = LEN_W + CHUNK_W;

   logic [ADDR_W-1:0]  ofs_full;
   logic [CHUNK_W-1:0] room;
   logic [CHUNK_W-1:0] chunk;
   logic [ADDR_W-1:0]  operand;
   logic [ADDR_W-1:0]  sum;

   always_comb begin
      ofs_full = addr & ADDR_W'(BLOCK_BYTES - 1);
      room     = CHUNK_W'(BLOCK_BYTES) - CHUNK_W'(ofs_full);
      if (CMP_W'(left) < CMP_W'(room)) begin
         chunk = CHUNK_W'(left);
      end else begin
         chunk = room;
      end
      // The one adder serves the end-of-array check and every address advance.
      operand = check_mode ? ADDR_W'(left) : ADDR_W'(chunk);
      sum     = addr + operand;

      step.disk      = DISK_W'(addr >> DISK_SHIFT);
      step.block     = BLOCK_W'((addr >> BLOCK_SHIFT) & ADDR_W'(BLOCKS_PER_DISK - 1));
      step.ofs       = OFS_W'(ofs_full);
      step.chunk     = chunk;
      step.sum       = sum;
      step.next_left = left - LEN_W'(chunk);
      step.next_block_zero =
         ((sum >> BLOCK_SHIFT) & ADDR_W'(BLOCKS_PER_DISK - 1)) == '0;
   end

endmodule
